@@ rtl/core/ttok_pkg.sv @@
// Package for the toy language tokenizer: token codes, scanner modes,
// result and queue entry types, and the keyword match function.
// No dependencies.
package ttok_pkg;

    localparam int MAX_WORD = 16;
    localparam int BUF_N    = 8;
    localparam int BUF_W    = $clog2(BUF_N);
    localparam int Q_DEPTH  = 4;
    localparam int Q_AW     = $clog2(Q_DEPTH);
    localparam int N_RES    = 3;

    localparam logic [4:0] K_PROGRAM = 5'd0;
    localparam logic [4:0] K_PRINT   = 5'd1;
    localparam logic [4:0] K_INTKW   = 5'd2;
    localparam logic [4:0] K_END     = 5'd3;
    localparam logic [4:0] K_FLOAT   = 5'd4;
    localparam logic [4:0] K_BOOLKW  = 5'd5;
    localparam logic [4:0] K_ELSE    = 5'd6;
    localparam logic [4:0] K_IF      = 5'd7;
    localparam logic [4:0] K_THEN    = 5'd8;
    localparam logic [4:0] K_IDENT   = 5'd9;
    localparam logic [4:0] K_INT     = 5'd10;
    localparam logic [4:0] K_REAL    = 5'd11;
    localparam logic [4:0] K_STR     = 5'd12;
    localparam logic [4:0] K_BOOL    = 5'd13;
    localparam logic [4:0] K_PLUS    = 5'd14;
    localparam logic [4:0] K_MINUS   = 5'd15;
    localparam logic [4:0] K_MULT    = 5'd16;
    localparam logic [4:0] K_DIV     = 5'd17;
    localparam logic [4:0] K_ASSOP   = 5'd18;
    localparam logic [4:0] K_EQUAL   = 5'd19;
    localparam logic [4:0] K_GTHAN   = 5'd20;
    localparam logic [4:0] K_LTHAN   = 5'd21;
    localparam logic [4:0] K_AND     = 5'd22;
    localparam logic [4:0] K_OR      = 5'd23;
    localparam logic [4:0] K_NOT     = 5'd24;
    localparam logic [4:0] K_COMMA   = 5'd25;
    localparam logic [4:0] K_LPAREN  = 5'd26;
    localparam logic [4:0] K_RPAREN  = 5'd27;
    localparam logic [4:0] K_SEMI    = 5'd28;
    localparam logic [4:0] K_ERR     = 5'd29;
    localparam logic [4:0] K_DONE    = 5'd30;

    typedef enum logic [6:0] {
        M_START = 7'b0000001,
        M_ID    = 7'b0000010,
        M_INT   = 7'b0000100,
        M_REAL  = 7'b0001000,
        M_STR   = 7'b0010000,
        M_LCOM  = 7'b0100000,
        M_BCOM  = 7'b1000000
    } t_mode;

    typedef struct packed {
        logic [4:0]  kind;
        logic [15:0] line;
        logic [7:0]  len;
    } t_res;

    typedef struct packed {
        logic [1:0]             cnt;
        t_res [N_RES-1:0]       res;
    } t_entry;

    typedef struct packed {
        logic [63:0] text;
        logic [7:0]  len;
        logic [4:0]  kind;
    } t_kw;

    localparam int N_KW = 11;
    localparam t_kw KW_TAB [N_KW] = '{
        '{{"PROGRAM", 8'h00}, 8'd7, K_PROGRAM},
        '{{"PRINT", 24'h0},   8'd5, K_PRINT},
        '{{"INT", 40'h0},     8'd3, K_INTKW},
        '{{"END", 40'h0},     8'd3, K_END},
        '{{"FLOAT", 24'h0},   8'd5, K_FLOAT},
        '{{"BOOL", 32'h0},    8'd4, K_BOOLKW},
        '{{"ELSE", 32'h0},    8'd4, K_ELSE},
        '{{"IF", 48'h0},      8'd2, K_IF},
        '{{"THEN", 32'h0},    8'd4, K_THEN},
        '{{"TRUE", 32'h0},    8'd4, K_BOOL},
        '{{"FALSE", 24'h0},   8'd5, K_BOOL}
    };

    function automatic t_res mk_res(logic [4:0] kind, logic [15:0] line, logic [7:0] len);
        t_res r;
        r.kind = kind;
        r.line = line;
        r.len  = len;
        return r;
    endfunction

    function automatic logic [4:0] kw_class(logic [7:0] buf_q [BUF_N], logic [7:0] len);
        logic [63:0] word;
        logic [63:0] mask;
        logic [4:0]  kind;
        word = '0;
        kind = K_IDENT;
        for (int j = 0; j < 8; j++) begin
            word[63-8*j -: 8] = buf_q[j];
        end
        for (int i = N_KW - 1; i >= 0; i--) begin
            mask = 64'hFFFF_FFFF_FFFF_FFFF << (8 * (8 - int'(KW_TAB[i].len)));
            if (len == KW_TAB[i].len && (word & mask) == KW_TAB[i].text) begin
                kind = KW_TAB[i].kind;
            end
        end
        return kind;
    endfunction

endpackage

@@ rtl/core/ttok_if.sv @@
// Channel interfaces of the tokenizer: character words in, token words out.
// Depends on nothing.
interface ttok_in_if;
    logic       valid;
    logic       ready;
    logic [7:0] ch;
    logic [7:0] ahead;
    logic       final_char;
    modport source (output valid, ch, ahead, final_char, input ready);
    modport sink   (input valid, ch, ahead, final_char, output ready);
endinterface

interface ttok_out_if;
    logic        valid;
    logic        ready;
    logic [4:0]  token_kind;
    logic [15:0] line_number;
    logic [7:0]  token_length;
    logic        last_of_run;
    modport source (output valid, token_kind, line_number, token_length, last_of_run,
                    input ready);
    modport sink   (input valid, token_kind, line_number, token_length, last_of_run,
                    output ready);
endinterface

@@ rtl/core/ttok_front.sv @@
// Scanner front end: accepts one character word per cycle while the queue
// is not full, advances the scanner state and packs the tokens it finishes
// into one queue entry. Depends on ttok_pkg and ttok_if.
module ttok_front
    import ttok_pkg::*;
(
    input  logic         i_clk,
    input  logic         i_rst_n,
    ttok_in_if.sink      i_in,
    input  logic         i_full,
    output logic         o_push,
    output t_entry       o_entry
);

    t_mode       r_mode, n_mode;
    logic [7:0]  r_buf [BUF_N];
    logic [7:0]  n_buf [BUF_N];
    logic [7:0]  r_len, n_len;
    logic [15:0] r_line, n_line;
    logic        r_skip, n_skip;

    logic        acc;
    logic [7:0]  c, nx;
    logic        fin, has_nx;
    logic        do_start;
    logic [1:0]  ne;
    t_res [N_RES-1:0] e_res;
    logic        c_digit, c_alpha, c_space, c_delim, nx_digit;
    logic [7:0]  c_up;

    assign i_in.ready = !i_full;
    assign acc        = i_in.valid && !i_full;
    assign c          = i_in.ch;
    assign nx         = i_in.ahead;
    assign fin        = i_in.final_char;
    assign has_nx     = !fin;
    assign c_digit    = c >= "0" && c <= "9";
    assign nx_digit   = nx >= "0" && nx <= "9";
    assign c_alpha    = (c >= "A" && c <= "Z") || (c >= "a" && c <= "z");
    assign c_space    = c == " " || (c >= 8'd9 && c <= 8'd13);
    assign c_delim    = c == " " || c == 8'h0A || c == "*" || c == "+" || c == "-" ||
                        c == "=" || c == "/" || c == "," || c == ")" || c == ";";
    assign c_up       = (c >= "a" && c <= "z") ? c - 8'd32 : c;

    always_comb begin
        n_mode   = r_mode;
        n_buf    = r_buf;
        n_len    = r_len;
        n_line   = r_line;
        n_skip   = r_skip;
        do_start = 1'b0;
        ne       = 2'd0;
        e_res    = '0;

        if (r_skip) begin
            n_skip = 1'b0;
        end else begin
            case (r_mode)
                M_ID: begin
                    if (c_alpha || c_digit || c == "@" || c == "_") begin
                        if (r_len < 8'(MAX_WORD) && r_len < 8'(BUF_N)) begin
                            n_buf[r_len[BUF_W-1:0]] = c_up;
                        end
                        if (r_len != 8'hFF) n_len = r_len + 8'd1;
                    end else begin
                        e_res[ne] = mk_res(kw_class(r_buf, r_len), r_line, r_len);
                        ne = ne + 2'd1;
                        do_start = 1'b1;
                    end
                end
                M_INT, M_REAL: begin
                    if (c_digit) begin
                        if (r_len != 8'hFF) n_len = r_len + 8'd1;
                    end else if (r_mode == M_INT && c == "." && has_nx && nx_digit) begin
                        if (r_len != 8'hFF) n_len = r_len + 8'd1;
                        n_mode = M_REAL;
                    end else if (c_delim || (r_mode == M_INT && (c_alpha || c == "_"))) begin
                        e_res[ne] = mk_res((r_mode == M_INT) ? K_INT : K_REAL, r_line, r_len);
                        ne = ne + 2'd1;
                        do_start = 1'b1;
                    end else begin
                        e_res[ne] = mk_res(K_ERR, r_line,
                                           (r_len != 8'hFF) ? r_len + 8'd1 : r_len);
                        ne = ne + 2'd1;
                        n_mode = M_START;
                        n_len  = '0;
                    end
                end
                M_STR: begin
                    if (c == 8'h0A) begin
                        e_res[ne] = mk_res(K_ERR, r_line, r_len);
                        ne = ne + 2'd1;
                        if (r_line != 16'hFFFF) n_line = r_line + 16'd1;
                        n_mode = M_START;
                        n_len  = '0;
                    end else begin
                        if (r_len != 8'hFF) n_len = r_len + 8'd1;
                        if (c == "\"") begin
                            e_res[ne] = mk_res(K_STR, r_line, n_len);
                            ne = ne + 2'd1;
                            n_mode = M_START;
                            n_len  = '0;
                        end
                    end
                end
                M_LCOM: begin
                    if (c == 8'h0A) begin
                        if (r_line != 16'hFFFF) n_line = r_line + 16'd1;
                        n_mode = M_START;
                    end
                end
                M_BCOM: begin
                    if (r_len != 8'hFF) n_len = r_len + 8'd1;
                    if (c == "*" && has_nx && nx == "/") begin
                        n_skip = 1'b1;
                        n_mode = M_START;
                        n_len  = '0;
                    end else if (c == 8'h0A) begin
                        if (r_line != 16'hFFFF) n_line = r_line + 16'd1;
                    end
                end
                default: begin
                    do_start = 1'b1;
                end
            endcase
        end

        // A character that ends a token is scanned again in start mode.
        if (do_start) begin
            n_mode = M_START;
            n_len  = '0;
            if (c == 8'h0A) begin
                if (r_line != 16'hFFFF) n_line = r_line + 16'd1;
            end else if (c_space) begin
                n_len = '0;
            end else if (c_alpha || c == "_") begin
                n_buf[0] = c_up;
                n_len    = 8'd1;
                n_mode   = M_ID;
            end else if (c_digit) begin
                n_len  = 8'd1;
                n_mode = M_INT;
            end else if (c == "\"") begin
                n_len  = 8'd1;
                n_mode = M_STR;
            end else if (c == "/" && has_nx && nx == "/") begin
                n_mode = M_LCOM;
                n_skip = 1'b1;
            end else if (c == "/" && has_nx && nx == "*") begin
                n_len  = 8'd2;
                n_mode = M_BCOM;
                n_skip = 1'b1;
            end else if (c == "=" && has_nx && nx == "=") begin
                n_skip = 1'b1;
                e_res[ne] = mk_res(K_EQUAL, n_line, 8'd2);
                ne = ne + 2'd1;
            end else if (c == "&" && has_nx && nx == "&") begin
                n_skip = 1'b1;
                e_res[ne] = mk_res(K_AND, n_line, 8'd2);
                ne = ne + 2'd1;
            end else if (c == "|" && has_nx && nx == "|") begin
                n_skip = 1'b1;
                e_res[ne] = mk_res(K_OR, n_line, 8'd2);
                ne = ne + 2'd1;
            end else begin
                case (c)
                    "+":     e_res[ne] = mk_res(K_PLUS, n_line, 8'd1);
                    "-":     e_res[ne] = mk_res(K_MINUS, n_line, 8'd1);
                    "*":     e_res[ne] = mk_res(K_MULT, n_line, 8'd1);
                    "/":     e_res[ne] = mk_res(K_DIV, n_line, 8'd1);
                    "=":     e_res[ne] = mk_res(K_ASSOP, n_line, 8'd1);
                    ">":     e_res[ne] = mk_res(K_GTHAN, n_line, 8'd1);
                    "<":     e_res[ne] = mk_res(K_LTHAN, n_line, 8'd1);
                    "!":     e_res[ne] = mk_res(K_NOT, n_line, 8'd1);
                    ",":     e_res[ne] = mk_res(K_COMMA, n_line, 8'd1);
                    "(":     e_res[ne] = mk_res(K_LPAREN, n_line, 8'd1);
                    ")":     e_res[ne] = mk_res(K_RPAREN, n_line, 8'd1);
                    ";":     e_res[ne] = mk_res(K_SEMI, n_line, 8'd1);
                    default: e_res[ne] = mk_res(K_ERR, n_line, 8'd1);
                endcase
                ne = ne + 2'd1;
            end
        end

        // The end of the stream closes any open token and then reports DONE.
        // An entry holds at most three words, so a fourth one is dropped.
        if (fin) begin
            case (n_mode)
                M_ID: begin
                    e_res[ne] = mk_res(kw_class(n_buf, n_len), n_line, n_len);
                    ne = ne + 2'd1;
                end
                M_INT: begin
                    e_res[ne] = mk_res(K_INT, n_line, n_len);
                    ne = ne + 2'd1;
                end
                M_REAL: begin
                    e_res[ne] = mk_res(K_REAL, n_line, n_len);
                    ne = ne + 2'd1;
                end
                M_STR, M_BCOM: begin
                    e_res[ne] = mk_res(K_ERR, n_line, n_len);
                    ne = ne + 2'd1;
                end
                default: begin
                    n_len = n_len;
                end
            endcase
            n_mode = M_START;
            n_len  = '0;
            n_skip = 1'b0;
            if (ne != 2'd3) begin
                e_res[ne] = mk_res(K_DONE, n_line, 8'd0);
                ne = ne + 2'd1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mode <= M_START;
            r_len  <= '0;
            r_line <= '0;
            r_skip <= 1'b0;
        end else if (acc) begin
            r_mode <= n_mode;
            r_len  <= n_len;
            r_line <= n_line;
            r_skip <= n_skip;
        end
    end

    always_ff @(posedge i_clk) begin
        if (acc) begin
            r_buf <= n_buf;
        end
    end

    assign o_push      = acc && ne != 2'd0;
    assign o_entry.cnt = ne;
    assign o_entry.res = e_res;

endmodule

@@ rtl/core/ttok_queue.sv @@
// Short entry queue between the scanner and the token output stage.
// Depends on ttok_pkg.
module ttok_queue
    import ttok_pkg::*;
(
    input  logic    i_clk,
    input  logic    i_rst_n,
    input  logic    i_push,
    input  t_entry  i_entry,
    input  logic    i_pop,
    output logic    o_full,
    output logic    o_empty,
    output t_entry  o_head
);

    t_entry          r_mem [Q_DEPTH];
    logic [Q_AW-1:0] r_wp, r_rp;
    logic [Q_AW:0]   r_cnt;

    assign o_full  = r_cnt == (Q_AW+1)'(Q_DEPTH);
    assign o_empty = r_cnt == '0;
    assign o_head  = r_mem[r_rp];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= '0;
            r_rp  <= '0;
            r_cnt <= '0;
        end else begin
            if (i_push) r_wp <= r_wp + 1'b1;
            if (i_pop)  r_rp <= r_rp + 1'b1;
            if (i_push && !i_pop)      r_cnt <= r_cnt + 1'b1;
            else if (i_pop && !i_push) r_cnt <= r_cnt - 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_push) r_mem[r_wp] <= i_entry;
    end

endmodule

@@ rtl/core/ttok_back.sv @@
// Output stage: sends the tokens of the queue head entry one word per cycle
// while ready; marks each entry's last token. Uses ttok_pkg and ttok_if.
module ttok_back
    import ttok_pkg::*;
(
    input  logic         i_clk,
    input  logic         i_rst_n,
    input  logic         i_empty,
    input  t_entry       i_head,
    output logic         o_pop,
    ttok_out_if.source   o_out
);

    logic [1:0] r_sub;
    logic       last;
    t_res       cur;

    assign cur   = i_head.res[r_sub];
    assign last  = r_sub == i_head.cnt - 2'd1;
    assign o_pop = o_out.valid && o_out.ready && last;

    assign o_out.valid        = !i_empty;
    assign o_out.token_kind   = cur.kind;
    assign o_out.line_number  = cur.line;
    assign o_out.token_length = cur.len;
    assign o_out.last_of_run  = last;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_sub <= '0;
        end else if (o_out.valid && o_out.ready) begin
            r_sub <= last ? 2'd0 : r_sub + 2'd1;
        end
    end

endmodule

@@ rtl/core/toy_language_tokenizer.sv @@
// Top level of the toy language tokenizer: scanner, entry queue and output
// stage. Depends on ttok_pkg, ttok_if, ttok_front, ttok_queue and ttok_back.
//
// The tokenizer takes one source character word per cycle when its queue
// has room, so a stream is scanned at one byte per cycle; all scanner state
// and the keyword match update in the cycle a character is taken. Each
// character yields up to three token words, which leave a four-entry queue
// one per cycle while the receiver is ready; the sustained rate is one
// character per cycle if characters yield at most one token each on
// average. A token word is output in the cycle after its character is
// taken at earliest. After the last character a DONE word ends the stream.
module toy_language_tokenizer
    import ttok_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    ttok_in_if.sink     i_in,
    ttok_out_if.source  o_out
);

    logic   push, pop, full, empty;
    t_entry entry, head;

    ttok_front u_front (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_in    (i_in),
        .i_full  (full),
        .o_push  (push),
        .o_entry (entry)
    );

    ttok_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_entry (entry),
        .i_pop   (pop),
        .o_full  (full),
        .o_empty (empty),
        .o_head  (head)
    );

    ttok_back u_back (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_empty (empty),
        .i_head  (head),
        .o_pop   (pop),
        .o_out   (o_out)
    );

endmodule

@@ rtl/core/ttok_checker.sv @@
// Port checker for the tokenizer and its bind to the top level.
// Depends on ttok_pkg and toy_language_tokenizer.
module ttok_port_check
    import ttok_pkg::*;
(
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        i_valid,
    input logic        i_ready,
    input logic [4:0]  i_kind,
    input logic [7:0]  i_len,
    input logic        i_last
);

    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_valid && !i_ready |=> i_valid && $stable(i_kind) && $stable(i_len))
        else $error("stalled token word changed");

    a_done_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_valid && i_kind == K_DONE |-> i_last)
        else $error("DONE is not the last word of its character");

    a_done_len: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_valid && i_kind == K_DONE |-> i_len == 8'd0)
        else $error("DONE carries a length");

    a_kind: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_valid |-> i_kind <= K_DONE)
        else $error("token code out of range");

endmodule

bind toy_language_tokenizer ttok_port_check u_ttok_port_check (
    .i_clk   (i_clk),
    .i_rst_n (i_rst_n),
    .i_valid (o_out.valid),
    .i_ready (o_out.ready),
    .i_kind  (o_out.token_kind),
    .i_len   (o_out.token_length),
    .i_last  (o_out.last_of_run)
);
